// ===== rtl/ssf_pkg.sv =====
// Shared constants, types and lane helper for the state-space filter.
`default_nettype none

package ssf_pkg;

  localparam int LANES         = 4;
  localparam int LANE_W        = 16;
  localparam int REG_W         = 64;
  localparam int DATA_W        = 16;
  localparam int STATE_W       = 32;
  localparam int ORDER_W       = 3;
  localparam int CFG_INDEX_W   = 3;
  localparam int MAX_ORDER_DEF = 4;

  localparam int COEF_WIDTH    = 16;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int CW            = (COEF_WIDTH < LANE_W) ? COEF_WIDTH : LANE_W;
  localparam int SW            = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
  localparam int CF            = CW - 4;
  localparam int SF            = SW - 1;
  localparam int XF            = 16;
  localparam int ALIGN_SH      = XF - SF;
  localparam int OUT_SHIFT     = CF + XF - SF;
  localparam int STATE_SHIFT   = CF;
  localparam int ACC_W         = CW + STATE_W + 4;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PHI_ROW0 = 3'd0,
    CFG_PHI_ROW1 = 3'd1,
    CFG_PHI_ROW2 = 3'd2,
    CFG_PHI_ROW3 = 3'd3,
    CFG_GAMMA    = 3'd4,
    CFG_H_ROW    = 3'd5,
    CFG_J_GAIN   = 3'd6,
    CFG_ORDER    = 3'd7
  } cfg_index_t;

  function automatic logic signed [CW-1:0] lane(input logic [REG_W-1:0] packed_reg,
                                                input int idx);
    logic [REG_W-1:0] sh;
    sh = '0;
    if (idx >= LANES) begin
      return '0;
    end
    sh = packed_reg >> (LANE_W * idx);
    return signed'(sh[CW-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ssf_row.sv =====
// One dot product of coefficient lanes with the state plus a scaled input term, rounded and saturated.
`default_nettype none

module ssf_row #(
  parameter int N     = ssf_pkg::MAX_ORDER_DEF,
  parameter int SHIFT = ssf_pkg::STATE_SHIFT,
  parameter int OUT_W = ssf_pkg::STATE_W
) (
  input  wire logic [ssf_pkg::REG_W-1:0]          coefs,
  input  wire logic signed [ssf_pkg::CW-1:0]      bias,
  input  wire logic signed [ssf_pkg::SW-1:0]      u,
  input  wire logic signed [ssf_pkg::STATE_W-1:0] x [N],
  input  wire logic [N-1:0]                       active,
  output logic signed [OUT_W-1:0]                 value,
  output logic                                    sat
);

  localparam int ACC_W  = ssf_pkg::ACC_W;
  localparam int PROD_W = ssf_pkg::CW + ssf_pkg::STATE_W;
  localparam int BIAS_W = ssf_pkg::CW + ssf_pkg::SW;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd1 <<< (SHIFT - 1));
  localparam logic signed [ACC_W-1:0] HI  = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] LO  = -HI - ACC_W'(1);

  logic signed [BIAS_W-1:0] bias_prod;
  logic signed [PROD_W-1:0] prod [N];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shd;

  always_comb begin
    bias_prod = bias * u;
    for (int c = 0; c < N; c++) begin
      prod[c] = ssf_pkg::lane(coefs, c) * x[c];
    end
  end

  always_comb begin
    acc = ACC_W'(bias_prod) <<< ssf_pkg::ALIGN_SH;
    for (int c = 0; c < N; c++) begin
      if (active[c]) begin
        acc = acc + ACC_W'(prod[c]);
      end
    end
    shd = (acc + RND) >>> SHIFT;
    if (shd > HI) begin
      value = HI[OUT_W-1:0];
      sat   = 1'b1;
    end else if (shd < LO) begin
      value = LO[OUT_W-1:0];
      sat   = 1'b1;
    end else begin
      value = shd[OUT_W-1:0];
      sat   = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/state_space_filter_step.sv =====
// Top level of the fixed-point SISO state-space filter with stream ports and config writes.
//
//   port group  | direction | fields (lowest bit first)
//   s_*         | in        | tdata: sample_in[15:0]; tuser: opcode
//   m_*         | out       | tdata: sample_out[15:0]; tuser: saturated
//   cfg_*       | in        | cfg_index selects register, cfg_wdata carries its value
//
// One item per cycle while the output does not stall; a filter item passes the input
// register, then the result register, before it shows on the output. The state update
// is combinational from the state registers through the row units. A clear item yields
// no result. Reset clears state, config registers (order goes to four) and both stages.
// A stalled output holds its result; the input register still takes one more filter item.
`default_nettype none

module state_space_filter_step #(
  parameter int MAX_ORDER = ssf_pkg::MAX_ORDER_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [ssf_pkg::DATA_W-1:0]      s_tdata,   // sample_in
  input  wire logic                            s_tuser,   // opcode
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [ssf_pkg::DATA_W-1:0]           m_tdata,   // sample_out
  output logic                                 m_tuser,   // saturated
  input  wire logic                            cfg_wr_en,
  input  wire logic [ssf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ssf_pkg::REG_W-1:0]       cfg_wdata
);

  localparam int LANES   = ssf_pkg::LANES;
  localparam int REG_W   = ssf_pkg::REG_W;
  localparam int STATE_W = ssf_pkg::STATE_W;
  localparam int SW      = ssf_pkg::SW;
  localparam int DATA_W  = ssf_pkg::DATA_W;

  logic [REG_W-1:0]                 phi [LANES];
  logic [REG_W-1:0]                 gamma_column;
  logic [REG_W-1:0]                 h_row;
  logic [ssf_pkg::LANE_W-1:0]       j_gain;
  logic [ssf_pkg::ORDER_W-1:0]      order_in_use;

  logic                             in_valid;
  logic                             in_op;
  logic [DATA_W-1:0]                in_sample;
  logic                             out_valid;
  logic [DATA_W-1:0]                out_sample;
  logic                             out_sat;

  logic signed [STATE_W-1:0]        x [MAX_ORDER];
  logic signed [STATE_W-1:0]        x_next [MAX_ORDER];
  logic signed [STATE_W-1:0]        row_val [MAX_ORDER];
  logic [MAX_ORDER-1:0]             row_sat;
  logic [MAX_ORDER-1:0]             active;
  logic signed [SW-1:0]             u;
  logic signed [SW-1:0]             y;
  logic                             y_sat;
  logic                             flag;
  logic                             advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        phi[i] <= '0;
      end
      gamma_column <= '0;
      h_row        <= '0;
      j_gain       <= '0;
      order_in_use <= ssf_pkg::ORDER_W'(4);
    end else if (cfg_wr_en) begin
      unique case (ssf_pkg::cfg_index_t'(cfg_index))
        ssf_pkg::CFG_PHI_ROW0: phi[0]       <= cfg_wdata;
        ssf_pkg::CFG_PHI_ROW1: phi[1]       <= cfg_wdata;
        ssf_pkg::CFG_PHI_ROW2: phi[2]       <= cfg_wdata;
        ssf_pkg::CFG_PHI_ROW3: phi[3]       <= cfg_wdata;
        ssf_pkg::CFG_GAMMA:    gamma_column <= cfg_wdata;
        ssf_pkg::CFG_H_ROW:    h_row        <= cfg_wdata;
        ssf_pkg::CFG_J_GAIN:   j_gain       <= cfg_wdata[ssf_pkg::LANE_W-1:0];
        ssf_pkg::CFG_ORDER:    order_in_use <= cfg_wdata[ssf_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // order zero acts as one; orders above MAX_ORDER fall off the end of the mask
  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      active[i] = (i == 0) || (int'(order_in_use) > i);
    end
  end

  assign u = signed'(in_sample[SW-1:0]);

  ssf_row #(
    .N     (MAX_ORDER),
    .SHIFT (ssf_pkg::OUT_SHIFT),
    .OUT_W (SW)
  ) u_out_row (
    .coefs  (h_row),
    .bias   (ssf_pkg::lane(REG_W'(j_gain), 0)),
    .u      (u),
    .x      (x),
    .active (active),
    .value  (y),
    .sat    (y_sat)
  );

  for (genvar r = 0; r < MAX_ORDER; r++) begin : g_row
    if (r < LANES) begin : g_lane
      ssf_row #(
        .N     (MAX_ORDER),
        .SHIFT (ssf_pkg::STATE_SHIFT),
        .OUT_W (STATE_W)
      ) u_state_row (
        .coefs  (phi[r]),
        .bias   (ssf_pkg::lane(gamma_column, r)),
        .u      (u),
        .x      (x),
        .active (active),
        .value  (row_val[r]),
        .sat    (row_sat[r])
      );
    end else begin : g_none
      assign row_val[r] = '0;
      assign row_sat[r] = 1'b0;
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_ORDER; r++) begin
      x_next[r] = active[r] ? row_val[r] : '0;
    end
    flag = y_sat | (|(row_sat & active));
  end

  assign advance  = in_valid && ((in_op == ssf_pkg::OP_CLEAR) || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= s_tuser;
      in_sample <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_ORDER; r++) begin
        x[r] <= '0;
      end
    end else if (advance) begin
      for (int r = 0; r < MAX_ORDER; r++) begin
        x[r] <= (in_op == ssf_pkg::OP_CLEAR) ? '0 : x_next[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_op == ssf_pkg::OP_FILTER)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_op == ssf_pkg::OP_FILTER)) begin
      out_sample <= DATA_W'(y);
      out_sat    <= flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sample;
  assign m_tuser  = out_sat;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for state_space_filter_step: directed table, then random items.
module testbench;
  import ssf_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              sat;
  } filter_out_t;

  typedef struct packed {
    logic              is_write;
    cfg_index_t        reg_sel;
    logic [REG_W-1:0]  value;
    logic              op;
    logic [DATA_W-1:0] smp;
    logic              typed;
    logic [DATA_W-1:0] want_out;
    logic              want_sat;
  } plan_row_t;

  localparam int PLAN_LEN = 47;
  localparam int SEGMENTS = 22;
  localparam int SEG_ITEMS = 25;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_CLEAR,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, CFG_J_GAIN,   64'h1000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b1, 16'h8000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h0001, 1'b1, 16'h0001, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{1'b1, CFG_J_GAIN,   64'h7FFF, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b1, 16'h8000, 1'b1},
    '{1'b1, CFG_J_GAIN,   64'h8000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{1'b1, CFG_J_GAIN,   64'h0, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_GAMMA,    64'h1000100010001000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_H_ROW,    64'h1000100010001000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW0, 64'h0000000000001000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW1, 64'h0000000010000000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW2, 64'h0000100000000000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW3, 64'h1000000000000000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_ORDER,    64'h4, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h4000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'hC000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_CLEAR,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h1234, 1'b0, 16'h0000, 1'b0},
    '{1'b1, CFG_ORDER,    64'h0, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{1'b1, CFG_ORDER,    64'h7, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW0, 64'h7FFF7FFF7FFF7FFF, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW1, 64'h7FFF7FFF7FFF7FFF, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW2, 64'h7FFF7FFF7FFF7FFF, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW3, 64'h7FFF7FFF7FFF7FFF, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, CFG_ORDER,    64'h2, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW0, 64'h8000800080008000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW1, 64'h8000800080008000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW2, 64'h8000800080008000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b1, CFG_PHI_ROW3, 64'h8000800080008000, OP_FILTER, 16'h0, 1'b0, 16'h0, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_CLEAR,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_PHI_ROW0, 64'h0, OP_FILTER, 16'h0000, 1'b1, 16'h0000, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [DATA_W-1:0]      m_tdata;
  logic                   m_tuser;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_wdata;

  logic [REG_W-1:0]  phi_q [LANES];
  logic [REG_W-1:0]  gamma_q;
  logic [REG_W-1:0]  h_q;
  logic [DATA_W-1:0] j_q;
  logic [ORDER_W-1:0] order_q;
  longint            xs [MAX_ORDER_DEF];

  filter_out_t outputs_due [$];
  int          bad_results = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  state_space_filter_step dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic longint coef_at(input logic [REG_W-1:0] packed_coefs, input int idx);
    logic signed [LANE_W-1:0] c;
    c = packed_coefs[LANE_W*idx +: LANE_W];
    return longint'(c);
  endfunction

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(input longint v, input int w, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic filter_out_t filter_step(input logic [DATA_W-1:0] smp);
    int                       n;
    longint                   u;
    longint                   acc;
    longint                   y;
    longint                   nxt [MAX_ORDER_DEF];
    logic                     hit;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] jc;
    filter_out_t              res;
    hit = 1'b0;
    n = int'(order_q);
    if (n == 0) n = 1;
    if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
    s = smp;
    jc = j_q;
    u = longint'(s);
    acc = longint'(jc) * u * (longint'(1) << ALIGN_SH);
    for (int c = 0; c < n; c++) acc += coef_at(h_q, c) * xs[c];
    y = clip(round_half_up(acc, OUT_SHIFT), DATA_W, hit);
    for (int r = 0; r < MAX_ORDER_DEF; r++) begin
      if (r >= n) begin
        nxt[r] = 0;
      end else begin
        acc = coef_at(gamma_q, r) * u * (longint'(1) << ALIGN_SH);
        for (int c = 0; c < n; c++) acc += coef_at(phi_q[r], c) * xs[c];
        nxt[r] = clip(round_half_up(acc, STATE_SHIFT), STATE_W, hit);
      end
    end
    for (int r = 0; r < MAX_ORDER_DEF; r++) xs[r] = nxt[r];
    res.sample = y[DATA_W-1:0];
    res.sat = hit;
    return res;
  endfunction

  function automatic logic [LANE_W-1:0] pick_coef(input int style);
    int v;
    case (style)
      0: begin
        v = int'($urandom);
      end
      1: begin
        v = int'($urandom_range(1800)) - 900;
      end
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF;
          1: v = 32'h8000;
          2: v = 0;
          3: v = 32'h1000;
          default: v = 32'hF000;
        endcase
      end
      default: begin
        v = int'($urandom_range(6144)) - 3072;
      end
    endcase
    return v[LANE_W-1:0];
  endfunction

  function automatic logic [REG_W-1:0] pick_lanes(input int style);
    logic [REG_W-1:0] w;
    for (int i = 0; i < LANES; i++) w[LANE_W*i +: LANE_W] = pick_coef(style);
    return w;
  endfunction

  task automatic write_reg(input cfg_index_t sel, input logic [REG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    case (sel)
      CFG_PHI_ROW0, CFG_PHI_ROW1, CFG_PHI_ROW2, CFG_PHI_ROW3: phi_q[int'(sel)] = value;
      CFG_GAMMA:   gamma_q = value;
      CFG_H_ROW:   h_q = value;
      CFG_J_GAIN:  j_q = value[DATA_W-1:0];
      CFG_ORDER:   order_q = value[ORDER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(input logic op, input logic [DATA_W-1:0] smp, input logic typed,
                           input filter_out_t want);
    filter_out_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_CLEAR) begin
      for (int r = 0; r < MAX_ORDER_DEF; r++) xs[r] = 0;
    end else begin
      got = filter_step(smp);
      outputs_due.push_back(typed ? want : got);
    end
  endtask

  always @(posedge clk) begin : take_results
    filter_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outputs_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: sample_out %h saturated %b", m_tdata, m_tuser);
      end else begin
        want = outputs_due.pop_front();
        if (m_tdata !== want.sample || m_tuser !== want.sat) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected sample_out %h saturated %b, got %h %b",
                     want.sample, want.sat, m_tdata, m_tuser);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    logic              writing;
    logic              op;
    logic [DATA_W-1:0] smp;
    logic [REG_W-1:0]  word;
    int                style;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_FILTER;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_PHI_ROW0;
    cfg_wdata <= '0;
    for (int r = 0; r < LANES; r++) phi_q[r] = '0;
    for (int r = 0; r < MAX_ORDER_DEF; r++) xs[r] = 0;
    gamma_q = '0;
    h_q = '0;
    j_q = '0;
    order_q = ORDER_W'(4);
    writing = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_write) begin
        if (!writing) wait_idle();
        write_reg(PLAN[i].reg_sel, PLAN[i].value);
        writing = 1'b1;
      end else begin
        if (writing) cfg_wr_en <= 1'b0;
        writing = 1'b0;
        push_item(PLAN[i].op, PLAN[i].smp, PLAN[i].typed, {PLAN[i].want_out, PLAN[i].want_sat});
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      style = (seg == 0) ? 2 : int'($urandom_range(3));
      write_reg(CFG_PHI_ROW0, pick_lanes(style));
      write_reg(CFG_PHI_ROW1, pick_lanes(style));
      write_reg(CFG_PHI_ROW2, pick_lanes(style));
      write_reg(CFG_PHI_ROW3, pick_lanes(style));
      write_reg(CFG_GAMMA, pick_lanes(style));
      write_reg(CFG_H_ROW, pick_lanes(style));
      word = {$urandom(), $urandom()};
      word[LANE_W-1:0] = pick_coef(style);
      write_reg(CFG_J_GAIN, word);
      word = {$urandom(), $urandom()};
      write_reg(CFG_ORDER, word);
      cfg_wr_en <= 1'b0;
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 5 && k == 12) wait_idle();
        op = ($urandom_range(11) == 0) ? OP_CLEAR : OP_FILTER;
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0: smp = 16'h7FFF;
            1: smp = 16'h8000;
            2: smp = 16'h0000;
            default: smp = 16'hFFFF;
          endcase
        end else begin
          smp = DATA_W'($urandom);
        end
        push_item(op, smp, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
